### hw/rtl/ecl_pkg.sv
// ----------------------------------------------------------------------------
// ecl_pkg
// Shared types and constants for the expert tag cache with hot pinning.
// ----------------------------------------------------------------------------
`default_nettype none

package ecl_pkg;

  localparam int LAYER_W  = 8;
  localparam int EXPERT_W = 10;
  localparam int SIZE_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int USES_W   = 16;
  localparam int SLOT_W   = 6;
  localparam int BYTES_W  = 48;
  localparam int HELD_W   = 7;
  localparam int STAT_W   = 3;
  localparam int THR_W    = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);

  // command codes
  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_GET_HIT     = 3'd0,
    ST_GET_MISS    = 3'd1,
    ST_PUT_PRESENT = 3'd2,
    ST_PUT_EMPTY   = 3'd3,
    ST_PUT_EVICT   = 3'd4,
    ST_PUT_REJECT  = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } ctl_state_t;

  // one tag store entry as held in memory
  typedef struct packed {
    logic [LAYER_W-1:0]  layer;
    logic [EXPERT_W-1:0] expert;
    logic [STAMP_W-1:0]  stamp;
    logic [USES_W-1:0]   uses;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### hw/rtl/ecl_ram.sv
// ----------------------------------------------------------------------------
// ecl_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ecl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/expert_cache_lru_hot_pin.sv
// ----------------------------------------------------------------------------
// expert_cache_lru_hot_pin
// Fully associative tag store keyed by (layer, expert) with least recently
// stamped replacement and pinning of entries whose use count gets hot.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command beat (get or put of a layer/expert key with a byte size),
//           valid/ready handshake.
//   out_* : one result beat per command, valid/ready handshake, held in an
//           output register so the next command can be taken while it waits.
//   cfg_* : write of the hot threshold, taken on any cycle with cfg_wr_en;
//           write only while the block is idle.
// Timing: each command reads the entry memory once per entry through its
//   single read port, one entry per cycle, and compares each entry in the
//   cycle after its read, then does the update and write back in S_UPDATE.
//   in_ready rises in the same cycle as the result appears, so a new command
//   is taken only once the previous result has been registered.
// Reset (rst_n low, synchronous): all entries invalid and unpinned, counters
//   and totals zero, threshold 3. The entry memory itself is not cleared.
// Stall: if the result register is still full when an update is ready, the
//   update waits until out_ready frees the register; no beat is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module expert_cache_lru_hot_pin #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [ecl_pkg::THR_W-1:0]     cfg_wr_data,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [ecl_pkg::LAYER_W-1:0]   in_layer,
  input  wire logic [ecl_pkg::EXPERT_W-1:0]  in_expert,
  input  wire logic [ecl_pkg::SIZE_W-1:0]    in_weight_size,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ecl_pkg::STAT_W-1:0]         out_status,
  output logic [ecl_pkg::SLOT_W-1:0]         out_slot,
  output logic [ecl_pkg::LAYER_W-1:0]        out_victim_layer,
  output logic [ecl_pkg::EXPERT_W-1:0]       out_victim_expert,
  output logic [ecl_pkg::SIZE_W-1:0]         out_victim_size,
  output logic                               out_entry_hot,
  output logic [ecl_pkg::USES_W-1:0]         out_entry_uses,
  output logic [ecl_pkg::BYTES_W-1:0]        out_bytes_held,
  output logic [ecl_pkg::HELD_W-1:0]         out_entries_held,
  output logic [ecl_pkg::STAMP_W-1:0]        out_access_total,
  output logic [ecl_pkg::STAMP_W-1:0]        out_miss_total
);

  import ecl_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // --------------------------------------------------------------------------
  // control and bookkeeping state
  // --------------------------------------------------------------------------
  ctl_state_t           state_r, state_nxt;
  logic [CAPACITY-1:0]  valid_r, valid_nxt;
  logic [CAPACITY-1:0]  hot_r, hot_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [STAMP_W-1:0]   access_r, access_nxt;
  logic [STAMP_W-1:0]   miss_r, miss_nxt;
  logic [THR_W-1:0]     thr_r, thr_nxt;

  // scan pointers
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 issue_done_r, issue_done_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;

  // scan findings
  logic                 hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  entry_t               hit_ent_r, hit_ent_nxt;
  logic                 hit_hot_r, hit_hot_nxt;
  logic                 emp_found_r, emp_found_nxt;
  logic [IDX_W-1:0]     emp_idx_r, emp_idx_nxt;
  logic                 vic_found_r, vic_found_nxt;
  logic [IDX_W-1:0]     vic_idx_r, vic_idx_nxt;
  entry_t               vic_ent_r, vic_ent_nxt;

  // captured command
  logic                 cmd_r, cmd_nxt;
  logic [LAYER_W-1:0]   lay_r, lay_nxt;
  logic [EXPERT_W-1:0]  exp_r, exp_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;

  // result register
  logic                 ovld_r, ovld_nxt;
  logic [STAT_W-1:0]    ostat_r, ostat_nxt;
  logic [SLOT_W-1:0]    oslot_r, oslot_nxt;
  logic [LAYER_W-1:0]   ovl_r, ovl_nxt;
  logic [EXPERT_W-1:0]  ove_r, ove_nxt;
  logic [SIZE_W-1:0]    ovs_r, ovs_nxt;
  logic                 ohot_r, ohot_nxt;
  logic [USES_W-1:0]    ouses_r, ouses_nxt;

  // memory port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  entry_t               ram_rdata;

  // update helpers
  logic                 upd_go;
  logic [STAMP_W-1:0]   stamp_new;
  logic [USES_W-1:0]    uses_new;
  logic                 cur_valid;
  logic                 cur_hot;

  ecl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      hot_r        <= '0;
      cnt_r        <= '0;
      bytes_r      <= '0;
      access_r     <= '0;
      miss_r       <= '0;
      thr_r        <= THR_RESET;
      rd_idx_r     <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      emp_found_r  <= 1'b0;
      vic_found_r  <= 1'b0;
      ovld_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      hot_r        <= hot_nxt;
      cnt_r        <= cnt_nxt;
      bytes_r      <= bytes_nxt;
      access_r     <= access_nxt;
      miss_r       <= miss_nxt;
      thr_r        <= thr_nxt;
      rd_idx_r     <= rd_idx_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_found_r  <= hit_found_nxt;
      emp_found_r  <= emp_found_nxt;
      vic_found_r  <= vic_found_nxt;
      ovld_r       <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_ent_r <= hit_ent_nxt;
    hit_hot_r <= hit_hot_nxt;
    emp_idx_r <= emp_idx_nxt;
    vic_idx_r <= vic_idx_nxt;
    vic_ent_r <= vic_ent_nxt;
    cmd_r     <= cmd_nxt;
    lay_r     <= lay_nxt;
    exp_r     <= exp_nxt;
    size_r    <= size_nxt;
    ostat_r   <= ostat_nxt;
    oslot_r   <= oslot_nxt;
    ovl_r     <= ovl_nxt;
    ove_r     <= ove_nxt;
    ovs_r     <= ovs_nxt;
    ohot_r    <= ohot_nxt;
    ouses_r   <= ouses_nxt;
  end

  // --------------------------------------------------------------------------
  // helpers: entry under compare, saturating stamp and use count
  // --------------------------------------------------------------------------
  assign cur_valid = valid_r[cmp_idx_r];
  assign cur_hot   = hot_r[cmp_idx_r];
  assign upd_go    = !ovld_r || out_ready;
  assign stamp_new = (access_r == '1) ? access_r : access_r + STAMP_W'(1);
  assign uses_new  = (hit_ent_r.uses == '1) ? hit_ent_r.uses
                                             : hit_ent_r.uses + USES_W'(1);

  assign in_ready = (state_r == S_IDLE);
  assign ram_re   = (state_r == S_SCAN) && !issue_done_r;

  // --------------------------------------------------------------------------
  // sequencer: accept, scan all entries, update and write back
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    hot_nxt        = hot_r;
    cnt_nxt        = cnt_r;
    bytes_nxt      = bytes_r;
    access_nxt     = access_r;
    miss_nxt       = miss_r;
    thr_nxt        = cfg_wr_en ? cfg_wr_data : thr_r;
    rd_idx_nxt     = rd_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = rd_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    hit_hot_nxt    = hit_hot_r;
    emp_found_nxt  = emp_found_r;
    emp_idx_nxt    = emp_idx_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_ent_nxt    = vic_ent_r;
    cmd_nxt        = cmd_r;
    lay_nxt        = lay_r;
    exp_nxt        = exp_r;
    size_nxt       = size_r;
    ovld_nxt       = ovld_r && !out_ready;
    ostat_nxt      = ostat_r;
    oslot_nxt      = oslot_r;
    ovl_nxt        = ovl_r;
    ove_nxt        = ove_r;
    ovs_nxt        = ovs_r;
    ohot_nxt       = ohot_r;
    ouses_nxt      = ouses_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        // capture the command beat and arm the scan
        if (in_valid) begin
          cmd_nxt        = in_command;
          lay_nxt        = in_layer;
          exp_nxt        = in_expert;
          size_nxt       = in_weight_size;
          rd_idx_nxt     = '0;
          issue_done_nxt = 1'b0;
          hit_found_nxt  = 1'b0;
          emp_found_nxt  = 1'b0;
          vic_found_nxt  = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (!issue_done_r) begin
          cmp_vld_nxt = 1'b1;
          if (rd_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
        // examine the entry read in the previous cycle
        if (cmp_vld_r) begin
          if (!hit_found_r && cur_valid && ram_rdata.layer == lay_r &&
              ram_rdata.expert == exp_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = cmp_idx_r;
            hit_ent_nxt   = ram_rdata;
            hit_hot_nxt   = cur_hot;
          end
          if (!emp_found_r && !cur_valid) begin
            emp_found_nxt = 1'b1;
            emp_idx_nxt   = cmp_idx_r;
          end
          if (cur_valid && !cur_hot &&
              (!vic_found_r || ram_rdata.stamp < vic_ent_r.stamp)) begin
            vic_found_nxt = 1'b1;
            vic_idx_nxt   = cmp_idx_r;
            vic_ent_nxt   = ram_rdata;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_UPDATE;
          end
        end
      end

      S_UPDATE: begin
        // apply the command once the result register is free
        if (upd_go) begin
          ovld_nxt  = 1'b1;
          ovl_nxt   = '0;
          ove_nxt   = '0;
          ovs_nxt   = '0;
          oslot_nxt = '0;
          ohot_nxt  = 1'b0;
          ouses_nxt = '0;
          state_nxt = S_IDLE;
          if (hit_found_r) begin
            // refresh the entry found
            access_nxt      = stamp_new;
            ram_we          = 1'b1;
            ram_waddr       = hit_idx_r;
            ram_wdata       = hit_ent_r;
            ram_wdata.stamp = stamp_new;
            ram_wdata.uses  = uses_new;
            oslot_nxt       = SLOT_W'(hit_idx_r);
            ouses_nxt       = uses_new;
            if (cmd_r == CMD_GET) begin
              ostat_nxt = ST_GET_HIT;
              ohot_nxt  = hit_hot_r || (uses_new >= thr_r);
              hot_nxt[hit_idx_r] = hit_hot_r || (uses_new >= thr_r);
            end else begin
              ostat_nxt = ST_PUT_PRESENT;
              ohot_nxt  = hit_hot_r;
            end
          end else if (cmd_r == CMD_GET) begin
            ostat_nxt = ST_GET_MISS;
            miss_nxt  = (miss_r == '1) ? miss_r : miss_r + STAMP_W'(1);
          end else if (emp_found_r || vic_found_r) begin
            // fill an empty slot or replace the oldest unpinned entry
            access_nxt       = stamp_new;
            ram_we           = 1'b1;
            ram_waddr        = emp_found_r ? emp_idx_r : vic_idx_r;
            ram_wdata.layer  = lay_r;
            ram_wdata.expert = exp_r;
            ram_wdata.stamp  = stamp_new;
            ram_wdata.uses   = USES_W'(1);
            ram_wdata.size   = size_r;
            valid_nxt[ram_waddr] = 1'b1;
            hot_nxt[ram_waddr]   = 1'b0;
            oslot_nxt = SLOT_W'(ram_waddr);
            ouses_nxt = USES_W'(1);
            if (emp_found_r) begin
              ostat_nxt = ST_PUT_EMPTY;
              cnt_nxt   = cnt_r + CNT_W'(1);
              bytes_nxt = bytes_r + BYTES_W'(size_r);
            end else begin
              ostat_nxt = ST_PUT_EVICT;
              ovl_nxt   = vic_ent_r.layer;
              ove_nxt   = vic_ent_r.expert;
              ovs_nxt   = vic_ent_r.size;
              bytes_nxt = bytes_r - BYTES_W'(vic_ent_r.size) + BYTES_W'(size_r);
            end
          end else begin
            ostat_nxt = ST_PUT_REJECT;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result ports
  // --------------------------------------------------------------------------
  assign out_valid         = ovld_r;
  assign out_status        = ostat_r;
  assign out_slot          = oslot_r;
  assign out_victim_layer  = ovl_r;
  assign out_victim_expert = ove_r;
  assign out_victim_size   = ovs_r;
  assign out_entry_hot     = ohot_r;
  assign out_entry_uses    = ouses_r;
  assign out_bytes_held    = bytes_r;
  assign out_entries_held  = HELD_W'(cnt_r);
  assign out_access_total  = access_r;
  assign out_miss_total    = miss_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // entry count never exceeds the number of slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above capacity");

  // a reject only happens with every slot occupied
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && ostat_r == ST_PUT_REJECT) |-> (cnt_r == FULL_CNT))
    else $error("put rejected with a free slot");

  // a touched entry always reports a nonzero use count
  a_uses_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && (ostat_r == ST_GET_HIT || ostat_r == ST_PUT_PRESENT ||
                ostat_r == ST_PUT_EMPTY || ostat_r == ST_PUT_EVICT))
    |-> (ouses_r != '0))
    else $error("touched entry with zero use count");

  // access counter never moves backward
  a_access_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (access_r >= $past(access_r)))
    else $error("access counter went backward");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for expert_cache_lru_hot_pin. A tracker class mirrors
// the tag store (lookup, fill, least recently stamped eviction, hot pinning,
// saturating counters) and checks every result beat against it. A short
// directed run is followed by random phases over several thresholds, with
// random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import ecl_pkg::*;

  localparam int ENTRIES    = 64;
  localparam int POOL_KEYS  = 128;
  localparam int PHASES     = 5;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 2 * ENTRIES + 8;
  localparam int CYCLE_CAP  = 800000;

  // one expected or observed result beat
  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [LAYER_W-1:0]   victim_layer;
    logic [EXPERT_W-1:0]  victim_expert;
    logic [SIZE_W-1:0]    victim_size;
    logic                 entry_hot;
    logic [USES_W-1:0]    entry_uses;
    logic [BYTES_W-1:0]   bytes_held;
    logic [HELD_W-1:0]    entries_held;
    logic [STAMP_W-1:0]   access_total;
    logic [STAMP_W-1:0]   miss_total;
  } cache_result_t;

  // mirror of the tag store and queue of predicted result beats
  class tag_store_tracker;
    bit                  valid_q[ENTRIES];
    bit                  hot_q[ENTRIES];
    logic [LAYER_W-1:0]  layer_tag[ENTRIES];
    logic [EXPERT_W-1:0] expert_tag[ENTRIES];
    logic [STAMP_W-1:0]  stamp_q[ENTRIES];
    logic [USES_W-1:0]   uses_q[ENTRIES];
    logic [SIZE_W-1:0]   size_q[ENTRIES];
    logic [HELD_W-1:0]   held_count;
    logic [BYTES_W-1:0]  byte_sum;
    logic [STAMP_W-1:0]  stamp_ctr;
    logic [STAMP_W-1:0]  lookup_misses;
    logic [THR_W-1:0]    threshold;
    cache_result_t       pending_results[$];
    int                  mismatches;
    int                  beats_checked;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] = 1'b0;
        hot_q[i]   = 1'b0;
      end
      held_count    = '0;
      byte_sum      = '0;
      stamp_ctr     = '0;
      lookup_misses = '0;
      threshold     = THR_RESET;
      mismatches    = 0;
      beats_checked = 0;
    endfunction

    // saturating access counter, new value is the recency stamp
    function logic [STAMP_W-1:0] next_stamp();
      if (stamp_ctr != '1) stamp_ctr++;
      return stamp_ctr;
    endfunction

    function logic [USES_W-1:0] bump_uses(logic [USES_W-1:0] u);
      return (u != '1) ? u + USES_W'(1) : u;
    endfunction

    // apply one accepted command and queue the result it must produce
    function void note_command(cmd_t cmd, logic [LAYER_W-1:0] layer,
                               logic [EXPERT_W-1:0] expert, logic [SIZE_W-1:0] size);
      cache_result_t r;
      int hit;
      int empty;
      int victim;
      int e;
      logic [STAMP_W-1:0] oldest;
      r = '0;
      hit = -1;
      empty = -1;
      victim = -1;
      oldest = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && layer_tag[i] == layer && expert_tag[i] == expert) begin
          hit = i;
          break;
        end
      end
      if (cmd == CMD_GET) begin
        if (hit >= 0) begin
          stamp_q[hit] = next_stamp();
          uses_q[hit]  = bump_uses(uses_q[hit]);
          if (uses_q[hit] >= threshold) hot_q[hit] = 1'b1;
          r.status     = ST_GET_HIT;
          r.slot       = SLOT_W'(hit);
          r.entry_hot  = hot_q[hit];
          r.entry_uses = uses_q[hit];
        end else begin
          if (lookup_misses != '1) lookup_misses++;
          r.status = ST_GET_MISS;
        end
      end else if (hit >= 0) begin
        // refresh only, size kept and never pinned here
        stamp_q[hit] = next_stamp();
        uses_q[hit]  = bump_uses(uses_q[hit]);
        r.status     = ST_PUT_PRESENT;
        r.slot       = SLOT_W'(hit);
        r.entry_hot  = hot_q[hit];
        r.entry_uses = uses_q[hit];
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!valid_q[i]) begin
            empty = i;
            break;
          end
        end
        // oldest unpinned entry, lowest index on equal stamps
        if (empty < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && !hot_q[i] && (victim < 0 || stamp_q[i] < oldest)) begin
              victim = i;
              oldest = stamp_q[i];
            end
          end
        end
        if (empty < 0 && victim < 0) begin
          r.status = ST_PUT_REJECT;
        end else begin
          if (empty >= 0) begin
            e = empty;
            r.status = ST_PUT_EMPTY;
          end else begin
            e = victim;
            r.status        = ST_PUT_EVICT;
            r.victim_layer  = layer_tag[e];
            r.victim_expert = expert_tag[e];
            r.victim_size   = size_q[e];
            byte_sum   = byte_sum - BYTES_W'(size_q[e]);
            held_count = held_count - HELD_W'(1);
          end
          valid_q[e]    = 1'b1;
          hot_q[e]      = 1'b0;
          layer_tag[e]  = layer;
          expert_tag[e] = expert;
          stamp_q[e]    = next_stamp();
          uses_q[e]     = USES_W'(1);
          size_q[e]     = size;
          held_count    = held_count + HELD_W'(1);
          byte_sum      = byte_sum + BYTES_W'(size);
          r.slot        = SLOT_W'(e);
          r.entry_uses  = USES_W'(1);
        end
      end
      r.bytes_held   = byte_sum;
      r.entries_held = held_count;
      r.access_total = stamp_ctr;
      r.miss_total   = lookup_misses;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %0h, got %0h", beats_checked, name, want, got);
      end
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(cache_result_t got);
      cache_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with no command outstanding: status %0d slot %0d",
                   got.status, got.slot);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot", want.slot, got.slot);
      compare_field("victim_layer", want.victim_layer, got.victim_layer);
      compare_field("victim_expert", want.victim_expert, got.victim_expert);
      compare_field("victim_size", want.victim_size, got.victim_size);
      compare_field("entry_hot", want.entry_hot, got.entry_hot);
      compare_field("entry_uses", want.entry_uses, got.entry_uses);
      compare_field("bytes_held", want.bytes_held, got.bytes_held);
      compare_field("entries_held", want.entries_held, got.entries_held);
      compare_field("access_total", want.access_total, got.access_total);
      compare_field("miss_total", want.miss_total, got.miss_total);
      beats_checked++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [THR_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = 1'b0;
  logic [LAYER_W-1:0]   in_layer = '0;
  logic [EXPERT_W-1:0]  in_expert = '0;
  logic [SIZE_W-1:0]    in_weight_size = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [SLOT_W-1:0]    out_slot;
  logic [LAYER_W-1:0]   out_victim_layer;
  logic [EXPERT_W-1:0]  out_victim_expert;
  logic [SIZE_W-1:0]    out_victim_size;
  logic                 out_entry_hot;
  logic [USES_W-1:0]    out_entry_uses;
  logic [BYTES_W-1:0]   out_bytes_held;
  logic [HELD_W-1:0]    out_entries_held;
  logic [STAMP_W-1:0]   out_access_total;
  logic [STAMP_W-1:0]   out_miss_total;

  tag_store_tracker     tracker = new();
  bit                   sender_idles = 1'b1;
  bit                   sink_idles = 1'b1;
  bit                   hold_request = 1'b0;
  int                   cycles = 0;
  logic [LAYER_W-1:0]   pool_layer[POOL_KEYS];
  logic [EXPERT_W-1:0]  pool_expert[POOL_KEYS];

  // per phase: threshold, item count, key pool size, put percentage
  int unsigned phase_thr[PHASES]   = '{65535, 12, 2, 0, 1};
  int          phase_items[PHASES] = '{450, 400, 350, 300, 400};
  int          phase_pool[PHASES]  = '{100, 90, 80, 100, 128};
  int          phase_puts[PHASES]  = '{50, 45, 40, 50, 50};

  expert_cache_lru_hot_pin #(.CAPACITY(ENTRIES)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_layer          (in_layer),
    .in_expert         (in_expert),
    .in_weight_size    (in_weight_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_victim_layer  (out_victim_layer),
    .out_victim_expert (out_victim_expert),
    .out_victim_size   (out_victim_size),
    .out_entry_hot     (out_entry_hot),
    .out_entry_uses    (out_entry_uses),
    .out_bytes_held    (out_bytes_held),
    .out_entries_held  (out_entries_held),
    .out_access_total  (out_access_total),
    .out_miss_total    (out_miss_total)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_result(cache_result_t'{status_t'(out_status), out_slot,
                               out_victim_layer, out_victim_expert, out_victim_size,
                               out_entry_hot, out_entry_uses, out_bytes_held,
                               out_entries_held, out_access_total, out_miss_total});
      if (in_valid && in_ready)
        tracker.note_command(cmd_t'(in_command), in_layer, in_expert, in_weight_size);
    end
  end

  // result sink with random stalls and one long hold-off on request
  initial begin : result_sink
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // run limit
  initial begin : watchdog
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("expert_cache_lru_hot_pin test failed");
    $finish;
  end

  // offer one command beat and hold it until accepted
  task automatic send_command(cmd_t cmd, logic [LAYER_W-1:0] layer,
                              logic [EXPERT_W-1:0] expert, logic [SIZE_W-1:0] size);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_layer       <= layer;
    in_expert      <= expert;
    in_weight_size <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted beat has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.threshold = value;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(0, 4096));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int pick;
    cmd_t cmd;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_layer[i]  = LAYER_W'($urandom);
      pool_expert[i] = EXPERT_W'($urandom);
    end

    // synchronous reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty miss, key extremes, present put, pinning at threshold 3
    send_command(CMD_GET, 8'h00, 10'h000, 32'h0000_0000);
    send_command(CMD_PUT, 8'h00, 10'h000, 32'h0000_0000);
    send_command(CMD_PUT, 8'hFF, 10'h3FF, 32'hFFFF_FFFF);
    send_command(CMD_PUT, 8'hFF, 10'h3FF, 32'h0000_0005);
    send_command(CMD_GET, 8'hFF, 10'h3FF, 32'h0000_0000);
    send_command(CMD_GET, 8'h00, 10'h000, 32'hFFFF_FFFF);
    send_command(CMD_GET, 8'h00, 10'h000, 32'h0000_0000);
    send_command(CMD_GET, 8'h00, 10'h000, 32'h0000_0000);
    send_command(CMD_PUT, 8'h00, 10'h3FF, 32'h0000_0001);
    send_command(CMD_GET, 8'hFF, 10'h000, 32'h0000_0000);
    send_command(CMD_PUT, 8'hAA, 10'h2AA, 32'hAAAA_AAAA);
    send_command(CMD_PUT, 8'h55, 10'h155, 32'h5555_5555);
    send_command(CMD_PUT, 8'h00, 10'h000, 32'h1234_5678);
    send_command(CMD_GET, 8'h55, 10'h155, 32'h0000_0000);
    send_command(CMD_PUT, 8'hFF, 10'h000, 32'hFFFF_FFFF);
    drain_results();

    // random phases, pinning grows as the threshold drops
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(THR_W'(phase_thr[p]));
      if (p == PHASES - 1) begin
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 0 && n == 200) hold_request = 1'b1;
        pick = $urandom_range(0, 99);
        cmd  = ($urandom_range(0, 99) < phase_puts[p]) ? CMD_PUT : CMD_GET;
        if (pick < 8)
          send_command(cmd, LAYER_W'($urandom), EXPERT_W'($urandom), pick_size());
        else begin
          pick = $urandom_range(0, phase_pool[p] - 1);
          send_command(cmd, pool_layer[pick], pool_expert[pick], pick_size());
        end
      end
      drain_results();
    end

    // let any stray beat show up before the verdict
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("expert_cache_lru_hot_pin test passed");
    else
      $display("expert_cache_lru_hot_pin test failed");
    $finish;
  end

endmodule
